// ===== src/vtv_pkg.sv =====
// Shared constants, types and helpers for the vertex transform and viewport unit.
`default_nettype none

package vtv_pkg;

	// Fixed-point format of coordinates and matrix entries.
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int RES_W     = 16;
	localparam int IDX_W     = 4;
	localparam int ENTRIES   = 16;

	// Column sum of four exact 64-bit products.
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = PROD_W + 2;

	// Window mapping: numerator clip * resolution, denominator 2 * w.
	localparam int NUM_W  = DATA_W + RES_W;
	localparam int NMAG_W = NUM_W - 1 + FRAC_BITS;
	localparam int DEN_W  = DATA_W + 1;
	// Quotient bits kept before the result is known to saturate.
	localparam int QB     = (FRAC_BITS + 18 > 34) ? FRAC_BITS + 18 : 34;
	localparam int REM_W  = (NMAG_W > DEN_W + QB) ? NMAG_W : DEN_W + QB;
	localparam int SCR_W  = QB + 3;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Input action codes.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_XFORM = 1'b1;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW_WIDTH  = 4'd0,
		REG_WINDOW_HEIGHT = 4'd1,
		REG_CENTER_X      = 4'd2,
		REG_CENTER_Y      = 4'd3
	} reg_index_t;

	// Window settings seen by the back part.
	typedef struct packed {
		logic [RES_W-1:0] width;
		logic [RES_W-1:0] height;
		logic [RES_W-1:0] cx;
		logic [RES_W-1:0] cy;
	} view_cfg_t;

	// One transformed point as it travels through the queue.
	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
		logic [DATA_W-1:0] w;
		logic              batch;
	} clip_item_t;

	// Reset value of one matrix entry: 1.0 on the diagonal, zero elsewhere.
	function automatic logic [DATA_W-1:0] ident_entry(input logic [IDX_W-1:0] idx);
		logic [DATA_W-1:0] v;
		v = '0;
		if (idx[1:0] == idx[3:2]) begin
			v = DATA_W'(1) << FRAC_BITS;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== src/vtv_queue.sv =====
// Small register queue that decouples the front part from the back part.
`default_nettype none

module vtv_queue
	import vtv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  clip_item_t push_item,
	output logic       full,
	input  logic       pop,
	output clip_item_t pop_item,
	output logic       empty
);

	clip_item_t          mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/vtv_front.sv =====
// Front part: accepts items, applies matrix loads, computes saturated clip coordinates.
`default_nettype none

module vtv_front
	import vtv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     action,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0] coefficient,
	input  logic signed [DATA_W-1:0] in_x,
	input  logic signed [DATA_W-1:0] in_y,
	input  logic signed [DATA_W-1:0] in_z,
	input  logic signed [DATA_W-1:0] in_w,
	input  logic                     end_of_batch,
	output logic                     push,
	output clip_item_t               push_item,
	input  logic                     full
);

	logic signed [DATA_W-1:0] matrix_q [0:ENTRIES-1];
	logic signed [DATA_W-1:0] pt [0:3];
	logic                     en;
	logic                     accept;

	logic                     v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] prod_s1 [0:3][0:3];
	logic                     batch_s1, batch_s2;
	logic signed [SUM_W-1:0]  sum_s2 [0:3];
	logic [DATA_W-1:0]        clip_s3 [0:3];
	logic                     batch_s3;

	// The pipeline moves as one unless its last item cannot enter the queue.
	assign en       = !v_s3 || !full;
	assign in_ready = en;
	assign accept   = in_valid && en;

	assign pt[0] = in_x;
	assign pt[1] = in_y;
	assign pt[2] = in_z;
	assign pt[3] = in_w;

	// Matrix store; a load takes effect before any later point is multiplied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				matrix_q[i] <= ident_entry(IDX_W'(i));
			end
		end else if (accept && action == ACT_LOAD) begin
			matrix_q[entry_index] <= coefficient;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && action == ACT_XFORM;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: sixteen exact products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= pt[i] * matrix_q[i*4+j];
				end
			end
			batch_s1 <= end_of_batch;
		end
	end

	// Stage 2: exact column sums.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				sum_s2[j] <= SUM_W'(prod_s1[0][j]) + SUM_W'(prod_s1[1][j])
					+ SUM_W'(prod_s1[2][j]) + SUM_W'(prod_s1[3][j]);
			end
			batch_s2 <= batch_s1;
		end
	end

	// Stage 3: drop the fraction toward minus infinity and saturate.
	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] sh;
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				sh = sum_s2[j] >>> FRAC_BITS;
				if (sh > SUM_W'(64'sd2147483647)) begin
					clip_s3[j] <= 32'h7FFF_FFFF;
				end else if (sh < -SUM_W'(64'sd2147483648)) begin
					clip_s3[j] <= 32'h8000_0000;
				end else begin
					clip_s3[j] <= sh[DATA_W-1:0];
				end
			end
			batch_s3 <= batch_s2;
		end
	end

	assign push            = v_s3 && !full;
	assign push_item.x     = clip_s3[0];
	assign push_item.y     = clip_s3[1];
	assign push_item.z     = clip_s3[2];
	assign push_item.w     = clip_s3[3];
	assign push_item.batch = batch_s3;

endmodule

`default_nettype wire

// ===== src/vtv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for window mapping.
`default_nettype none

module vtv_div
	import vtv_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [REM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [QB-1:0]     quo
);

	logic [REM_W-1:0] rem_s [1:QB];
	logic [DEN_W-1:0] den_s [1:QB];
	logic [QB-1:0]    quo_s [1:QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [REM_W-1:0] rem_src;
		logic [DEN_W-1:0] den_src;
		logic [QB-1:0]    quo_src;
		logic [REM_W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_src = num;
			assign den_src = den;
			assign quo_src = '0;
		end else begin : g_next
			assign rem_src = rem_s[k];
			assign den_src = den_s[k];
			assign quo_src = quo_s[k];
		end

		// Try to take the divisor at this bit position off the remainder.
		assign trial = {1'b0, rem_src} - ((REM_W+1)'(den_src) << (QB - 1 - k));

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= trial[REM_W] ? rem_src : trial[REM_W-1:0];
				den_s[k+1] <= den_src;
				quo_s[k+1] <= {quo_src[QB-2:0], !trial[REM_W]};
			end
		end
	end

	assign quo = quo_s[QB];

endmodule

`default_nettype wire

// ===== src/vtv_back.sv =====
// Back part: maps clip x and y to window coordinates and holds the output register.
`default_nettype none

module vtv_back
	import vtv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  view_cfg_t                cfg,
	input  logic                     empty,
	input  clip_item_t               pop_item,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] clip_x,
	output logic signed [DATA_W-1:0] clip_y,
	output logic signed [DATA_W-1:0] clip_z,
	output logic signed [DATA_W-1:0] clip_w,
	output logic signed [DATA_W-1:0] screen_x,
	output logic signed [DATA_W-1:0] screen_y,
	output logic                     w_zero,
	output logic                     batch_done
);

	typedef struct packed {
		clip_item_t clip;
		logic       wz;
		logic       neg_x;
		logic       neg_y;
		logic       ovf_x;
		logic       ovf_y;
	} side_t;

	logic                    en;
	logic                    v_s1, v_s2;
	logic                    vld_d [1:QB];
	logic                    out_valid_q;
	logic signed [NUM_W-1:0] num_x_s1, num_y_s1;
	logic signed [DEN_W-1:0] den_s1;
	clip_item_t              item_s1;
	logic [REM_W-1:0]        nmag_x_s2, nmag_y_s2;
	logic [DEN_W-1:0]        dmag_s2;
	side_t                   side_s2;
	side_t                   side_d [1:QB];
	logic [QB-1:0]           quo_x, quo_y;

	// Everything moves unless a finished item waits at the output.
	assign en        = !out_valid_q || out_ready;
	assign pop       = en && !empty;
	assign out_valid = out_valid_q;

	// Valid bits along the whole back pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 1; k <= QB; k++) begin
				vld_d[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1     <= !empty;
			v_s2     <= v_s1;
			vld_d[1] <= v_s2;
			for (int k = 2; k <= QB; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
			out_valid_q <= vld_d[QB];
		end
	end

	// Stage 1: numerators clip * resolution and denominator 2 * w.
	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s1 <= $signed(pop_item.x) * $signed({1'b0, cfg.width});
			num_y_s1 <= $signed(pop_item.y) * $signed({1'b0, cfg.height});
			den_s1   <= {pop_item.w, 1'b0};
			item_s1  <= pop_item;
		end
	end

	// Stage 2: magnitudes, quotient signs and the check for a huge quotient.
	always_ff @(posedge clk) begin
		logic [NUM_W-1:0] ax, ay;
		logic [DEN_W-1:0] ad;
		logic [REM_W:0]   lim;
		logic [REM_W-1:0] nx, ny;
		if (en) begin
			ax  = num_x_s1[NUM_W-1] ? NUM_W'(-num_x_s1) : NUM_W'(num_x_s1);
			ay  = num_y_s1[NUM_W-1] ? NUM_W'(-num_y_s1) : NUM_W'(num_y_s1);
			ad  = den_s1[DEN_W-1] ? DEN_W'(-den_s1) : DEN_W'(den_s1);
			nx  = REM_W'(ax) << FRAC_BITS;
			ny  = REM_W'(ay) << FRAC_BITS;
			lim = (REM_W+1)'(ad) << QB;
			nmag_x_s2     <= nx;
			nmag_y_s2     <= ny;
			dmag_s2       <= ad;
			side_s2.clip  <= item_s1;
			side_s2.wz    <= (item_s1.w == '0);
			side_s2.neg_x <= num_x_s1[NUM_W-1] ^ den_s1[DEN_W-1];
			side_s2.neg_y <= num_y_s1[NUM_W-1] ^ den_s1[DEN_W-1];
			side_s2.ovf_x <= ({1'b0, nx} >= lim);
			side_s2.ovf_y <= ({1'b0, ny} >= lim);
		end
	end

	// Two divider lanes share the denominator.
	vtv_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nmag_x_s2),
		.den (dmag_s2),
		.quo (quo_x)
	);

	vtv_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (nmag_y_s2),
		.den (dmag_s2),
		.quo (quo_y)
	);

	// Per-item side data travels beside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[1] <= side_s2;
			for (int k = 2; k <= QB; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// Signed quotient plus centre, saturated to 32 bits.
	function automatic logic [DATA_W-1:0] finish(input logic [QB-1:0] q,
		input logic neg, input logic ovf, input logic [RES_W-1:0] centre);
		logic [QB:0]             mag;
		logic signed [SCR_W-1:0] s;
		logic [DATA_W-1:0]       r;
		mag = ovf ? ((QB+1)'(1) << QB) : {1'b0, q};
		s   = neg ? -$signed(SCR_W'(mag)) : $signed(SCR_W'(mag));
		s   = s + $signed(SCR_W'(centre) << FRAC_BITS);
		if (s > SCR_W'(64'sd2147483647)) begin
			r = 32'h7FFF_FFFF;
		end else if (s < -SCR_W'(64'sd2147483648)) begin
			r = 32'h8000_0000;
		end else begin
			r = s[DATA_W-1:0];
		end
		return r;
	endfunction

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			clip_x     <= side_d[QB].clip.x;
			clip_y     <= side_d[QB].clip.y;
			clip_z     <= side_d[QB].clip.z;
			clip_w     <= side_d[QB].clip.w;
			batch_done <= side_d[QB].clip.batch;
			w_zero     <= side_d[QB].wz;
			if (side_d[QB].wz) begin
				screen_x <= '0;
				screen_y <= '0;
			end else begin
				screen_x <= finish(quo_x, side_d[QB].neg_x, side_d[QB].ovf_x, cfg.cx);
				screen_y <= finish(quo_y, side_d[QB].neg_y, side_d[QB].ovf_y, cfg.cy);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/vertex_transform_viewport_unit.sv =====
// Top level of the vertex transform and viewport unit.
`default_nettype none

// Points in Q16.16 are multiplied as row vectors by a stored 4x4 matrix and
// their clip x and y mapped to window coordinates; matrix loads share the
// input channel and give no result. The unit takes one item per clock cycle,
// loads and points alike, unless the input is stalled, and delivers one result
// per point in order. A point passes through the multiply, sum and saturate
// stages of the front, the four-entry queue, and the back part, whose length
// is set by the bit-per-stage window divider. The input stalls only when
// the queue is full; the output register holds a result until taken.
// Window settings may be rewritten only while no point is in flight.
module vertex_transform_viewport_unit
	import vtv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_index,
	input  logic [RES_W-1:0]         wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     action,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0] coefficient,
	input  logic signed [DATA_W-1:0] in_x,
	input  logic signed [DATA_W-1:0] in_y,
	input  logic signed [DATA_W-1:0] in_z,
	input  logic signed [DATA_W-1:0] in_w,
	input  logic                     end_of_batch,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] clip_x,
	output logic signed [DATA_W-1:0] clip_y,
	output logic signed [DATA_W-1:0] clip_z,
	output logic signed [DATA_W-1:0] clip_w,
	output logic signed [DATA_W-1:0] screen_x,
	output logic signed [DATA_W-1:0] screen_y,
	output logic                     w_zero,
	output logic                     batch_done
);

	view_cfg_t  cfg_q;
	logic       push, full, pop, empty;
	clip_item_t push_item, pop_item;

	// Window configuration registers; other indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RES_W'(640);
			cfg_q.height <= RES_W'(480);
			cfg_q.cx     <= RES_W'(320);
			cfg_q.cy     <= RES_W'(240);
		end else if (wr_en) begin
			case (wr_index)
				REG_WINDOW_WIDTH:  cfg_q.width  <= wr_data;
				REG_WINDOW_HEIGHT: cfg_q.height <= wr_data;
				REG_CENTER_X:      cfg_q.cx     <= wr_data;
				REG_CENTER_Y:      cfg_q.cy     <= wr_data;
				default: ;
			endcase
		end
	end

	vtv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.entry_index  (entry_index),
		.coefficient  (coefficient),
		.in_x         (in_x),
		.in_y         (in_y),
		.in_z         (in_z),
		.in_w         (in_w),
		.end_of_batch (end_of_batch),
		.push         (push),
		.push_item    (push_item),
		.full         (full)
	);

	vtv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	vtv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.empty      (empty),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.clip_x     (clip_x),
		.clip_y     (clip_y),
		.clip_z     (clip_z),
		.clip_w     (clip_w),
		.screen_x   (screen_x),
		.screen_y   (screen_y),
		.w_zero     (w_zero),
		.batch_done (batch_done)
	);

endmodule

`default_nettype wire

// ===== sim/vertex_transform_viewport_unit_tb.sv =====
// Self-checking testbench for the vertex transform and viewport unit.
`default_nettype none

module vertex_transform_viewport_unit_tb
	import vtv_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAX_Q = 32'h7fff_ffff;
	localparam logic [31:0] MIN_Q = 32'h8000_0000;

	// One result item of the unit.
	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [31:0] cw;
		logic [31:0] sx;
		logic [31:0] sy;
		logic        wz;
		logic        bd;
	} vtx_result_t;

	// One row of the directed stimulus table.
	typedef struct {
		logic        act;
		logic [3:0]  idx;
		logic [31:0] coef;
		logic [31:0] x, y, z, w;
		logic        eob;
		bit          typed;
		vtx_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [RES_W-1:0] wr_data;
	logic in_valid, in_ready;
	logic action;
	logic [IDX_W-1:0] entry_index;
	logic signed [DATA_W-1:0] coefficient, in_x, in_y, in_z, in_w;
	logic end_of_batch;
	logic out_valid, out_ready;
	logic signed [DATA_W-1:0] clip_x, clip_y, clip_z, clip_w, screen_x, screen_y;
	logic w_zero, batch_done;

	vertex_transform_viewport_unit u_dut (.*);

	// Shadow state of the unit.
	logic signed [31:0] matrix_shadow [16];
	logic [15:0] res_x, res_y, ctr_x, ctr_y;

	vtx_result_t expected_q[$];
	stim_row_t   directed[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	bit hold_req = 0;

	// Clock.
	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// Run-time limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] sat32(logic signed [65:0] v);
		if (v > 66'sd2147483647) return MAX_Q;
		if (v < -66'sd2147483648) return MIN_Q;
		return v[31:0];
	endfunction

	// Column j of the row vector times the matrix, floored back to Q16.16.
	function automatic logic [31:0] column_sum(logic signed [31:0] pt [4], int col);
		logic signed [65:0] acc;
		logic signed [63:0] prod;
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			prod = pt[i] * matrix_shadow[i*4 + col];
			acc = acc + prod;
		end
		return sat32(acc >>> FRAC_BITS);
	endfunction

	// Clip value scaled by resolution over twice w, plus the window center.
	function automatic logic [31:0] to_screen(logic signed [31:0] c, logic signed [31:0] w,
			logic [15:0] res, logic [15:0] ctr);
		longint num, den, q0, r, q, lim;
		num = longint'(c) * longint'(res);
		den = 2 * longint'(w);
		q0 = num / den;
		r = num % den;
		lim = longint'(1) << 33;
		if (q0 > lim) q0 = lim;
		if (q0 < -lim) q0 = -lim;
		q = q0 * (longint'(1) << FRAC_BITS) + (r * (longint'(1) << FRAC_BITS)) / den;
		q = q + longint'(ctr) * (longint'(1) << FRAC_BITS);
		return sat32(66'(q));
	endfunction

	function automatic vtx_result_t transform_point(logic [31:0] x, y, z, w, logic eob);
		logic signed [31:0] pt [4];
		vtx_result_t r;
		pt[0] = x; pt[1] = y; pt[2] = z; pt[3] = w;
		r.cx = column_sum(pt, 0);
		r.cy = column_sum(pt, 1);
		r.cz = column_sum(pt, 2);
		r.cw = column_sum(pt, 3);
		r.wz = (r.cw == 0);
		r.sx = r.wz ? 32'h0 : to_screen(r.cx, r.cw, res_x, ctr_x);
		r.sy = r.wz ? 32'h0 : to_screen(r.cy, r.cw, res_y, ctr_y);
		r.bd = eob;
		return r;
	endfunction

	// Offer one item in the current burst; update the shadow once it is taken.
	task automatic send_item(stim_row_t row);
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		action <= row.act;
		entry_index <= row.idx;
		coefficient <= row.coef;
		in_x <= row.x;
		in_y <= row.y;
		in_z <= row.z;
		in_w <= row.w;
		end_of_batch <= row.eob;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		if (row.act == ACT_LOAD) begin
			matrix_shadow[row.idx] = row.coef;
		end else if (row.typed) begin
			expected_q.push_back(row.res);
		end else begin
			expected_q.push_back(transform_point(row.x, row.y, row.z, row.w, row.eob));
		end
	endtask

	// One register write, after which the write port is left idle before the task returns.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (reg_index_t'(idx))
			REG_WINDOW_WIDTH:  res_x = val;
			REG_WINDOW_HEIGHT: res_y = val;
			REG_CENTER_X:      ctr_x = val;
			REG_CENTER_Y:      ctr_y = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return MAX_Q;
			1: return MIN_Q;
			2: return $urandom();
			default: return 32'($urandom_range(0, 1048575)) - 32'd524288;
		endcase
	endfunction

	function automatic stim_row_t rand_item();
		stim_row_t row;
		row.act = ($urandom_range(0, 3) == 0) ? ACT_LOAD : ACT_XFORM;
		row.idx = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 7))
			0: row.coef = $urandom();
			1: row.coef = 32'h0;
			default: row.coef = 32'($urandom_range(0, 262143)) - 32'd131072;
		endcase
		row.x = rand_coord();
		row.y = rand_coord();
		row.z = rand_coord();
		row.w = rand_coord();
		// An all-zero point gives a zero w.
		if ($urandom_range(0, 19) == 0) begin
			row.x = '0; row.y = '0; row.z = '0; row.w = '0;
		end
		row.eob = 1'($urandom_range(0, 1));
		row.typed = 1'b0;
		row.res = '0;
		return row;
	endfunction

	function automatic stim_row_t mk(logic act, logic [3:0] idx, logic [31:0] coef,
			logic [31:0] x, y, z, w, logic eob, bit typed, vtx_result_t res);
		stim_row_t row;
		row.act = act; row.idx = idx; row.coef = coef;
		row.x = x; row.y = y; row.z = z; row.w = w; row.eob = eob;
		row.typed = typed; row.res = res;
		return row;
	endfunction

	// Receiver: a randomly chosen ready pattern, plus a long hold-off.
	initial begin
		int hold_cnt;
		int mode;
		hold_cnt = 0;
		mode = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 300;
			end
			if (cycles % 64 == 0) mode = $urandom_range(0, 3);
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (cycles % 4 == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Compare each accepted result with the oldest expected one.
	always @(posedge clk) begin
		vtx_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got clip_x %h",
					$realtime, clip_x);
				errors++;
			end else begin
				e = expected_q.pop_front();
				check_field("clip_x", e.cx, clip_x);
				check_field("clip_y", e.cy, clip_y);
				check_field("clip_z", e.cz, clip_z);
				check_field("clip_w", e.cw, clip_w);
				check_field("screen_x", e.sx, screen_x);
				check_field("screen_y", e.sy, screen_y);
				check_field("w_zero", 32'(e.wz), 32'(w_zero));
				check_field("batch_done", 32'(e.bd), 32'(batch_done));
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0;
		in_valid = 1'b0; action = ACT_XFORM; entry_index = '0;
		coefficient = '0; in_x = '0; in_y = '0; in_z = '0; in_w = '0;
		end_of_batch = 1'b0;
		for (int i = 0; i < 16; i++) matrix_shadow[i] = (i % 5 == 0) ? ONE : 32'h0;
		res_x = 16'd640; res_y = 16'd480; ctr_x = 16'd320; ctr_y = 16'd240;

		// Directed items: identity after reset, extremes, zero w, loads.
		directed.push_back(mk(ACT_XFORM, 0, 0, ONE, 2*ONE, 3*ONE, ONE, 0, 1,
			{ONE, 32'h0002_0000, 32'h0003_0000, ONE, 32'h0280_0000, 32'h02D0_0000, 1'b0, 1'b0}));
		directed.push_back(mk(ACT_XFORM, 0, 0, ONE, ONE, ONE, 0, 1, 1,
			{ONE, ONE, ONE, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1}));
		directed.push_back(mk(ACT_XFORM, 0, 0, MAX_Q, MIN_Q, 0, ONE, 0, 1,
			{MAX_Q, MIN_Q, 32'h0, ONE, MAX_Q, MIN_Q, 1'b0, 1'b0}));
		directed.push_back(mk(ACT_XFORM, 0, 0, 0, 0, 0, 0, 1, 1,
			{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1}));
		directed.push_back(mk(ACT_LOAD, 0, MAX_Q, 0, 0, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 5, MIN_Q, 0, 0, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_XFORM, 0, 0, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 0, 0, '0));
		directed.push_back(mk(ACT_XFORM, 0, 0, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1, 0, '0));
		directed.push_back(mk(ACT_LOAD, 15, 0, 0, 0, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_XFORM, 0, 0, ONE, ONE, ONE, ONE, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 10, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 15, ONE, 0, 0, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 3, 32'h0000_8000, 0, 0, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_XFORM, 0, 0, 32'hFFFC_8000, 32'h0002_4000, 32'h0010_0000,
			32'hFFFF_0000, 1, 0, '0));
		directed.push_back(mk(ACT_XFORM, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678,
			32'h0000_0003, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 12, MAX_Q, 0, 0, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_XFORM, 0, 0, 0, 0, 0, MIN_Q, 1, 0, '0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_item(directed[i]);

		// Random phases, each under its own window setting.
		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					write_reg(REG_WINDOW_WIDTH, 16'h0);
					write_reg(REG_WINDOW_HEIGHT, 16'h0);
					write_reg(REG_CENTER_X, 16'h0);
					write_reg(REG_CENTER_Y, 16'h0);
					write_reg(4'(9), 16'hFFFF);
				end
				1: begin
					write_reg(REG_WINDOW_WIDTH, 16'hFFFF);
					write_reg(REG_WINDOW_HEIGHT, 16'hFFFF);
					write_reg(REG_CENTER_X, 16'hFFFF);
					write_reg(REG_CENTER_Y, 16'hFFFF);
					hold_req = 1;
				end
				default: begin
					write_reg(REG_WINDOW_WIDTH, 16'($urandom()));
					write_reg(REG_WINDOW_HEIGHT, 16'($urandom()));
					write_reg(REG_CENTER_X, 16'($urandom()));
					write_reg(REG_CENTER_Y, 16'($urandom()));
					write_reg(4'($urandom_range(4, 15)), 16'($urandom()));
				end
			endcase
			for (int n = 0; n < 435; n++) send_item(rand_item());
		end

		wait_idle();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
